// ----- sv/mips_subset_execute_with_control_lines_unit_macros.svh -----
// ---------------------------------------------------------------------------
// mips subset execute unit assertion macros
// shared assertion shorthands for the checker
// ---------------------------------------------------------------------------
`ifndef MIPS_SUBSET_EXECUTE_WITH_CONTROL_LINES_UNIT_MACROS_SVH
`define MIPS_SUBSET_EXECUTE_WITH_CONTROL_LINES_UNIT_MACROS_SVH
// implication checked at every edge outside reset
`define MSE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication checked outside reset
`define MSE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- sv/mse_pkg.sv -----
// ---------------------------------------------------------------------------
// mse_pkg
// types and constants shared by the execute unit modules
// ---------------------------------------------------------------------------
package mse_pkg;
  localparam int unsigned NumRegs = 32;
  localparam int unsigned DataW = 32;
  localparam int unsigned RegIdxW = 5;

  typedef enum logic [3:0] {
    FN_ADDI = 4'd0, FN_SUBI = 4'd1, FN_BEQ = 4'd2, FN_JUMP = 4'd3,
    FN_ADD = 4'd4, FN_SUB = 4'd5, FN_MUL = 4'd6, FN_DIV = 4'd7,
    FN_LW = 4'd8, FN_SW = 4'd9
  } func_t;

  localparam logic [2:0] CFG_REGWRITE = 3'd0;
  localparam logic [2:0] CFG_MEMREAD = 3'd1;
  localparam logic [2:0] CFG_MEMWRITE = 3'd2;
  localparam logic [2:0] CFG_BRANCH = 3'd3;
  localparam logic [2:0] CFG_JUMP = 3'd4;

  typedef struct packed {
    logic load;
    logic clear_step;
    logic rd_regs;
    logic exec;
    logic div_start;
  } mse_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic div_done;
  } mse_sts_t;
endpackage

// ----- sv/mips_subset_execute_with_control_lines_unit.sv -----
// ---------------------------------------------------------------------------
// mips_subset_execute_with_control_lines_unit
// executes one decoded mips subset instruction per transfer
// ---------------------------------------------------------------------------
// usage:
//   s_axis carries one decoded instruction per transfer; m_axis returns one
//   result per instruction. five control lines are set through cfg_we,
//   cfg_index and cfg_data; the user must set them only while the unit is
//   idle, as the unit itself does not enforce it. an instruction passes the
//   read, wait and execute states; a div also waits in the bit-serial divider.
//   one instruction is in flight at a time: the next transfer is taken only
//   after the result has been handed off on m_axis.
//   after reset the unit sweeps the data store to zero, one word per cycle,
//   with s_axis_tready low; registers reset at once. a stalled m_axis holds
//   the result and keeps s_axis_tready low.
module mips_subset_execute_with_control_lines_unit import mse_pkg::*; #(
  parameter int unsigned WORDS_PER_BASE = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // func, dest_reg, src_a_reg, src_b_reg, immediate, byte_offset, zero pad
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // redirect, reg_written, written_reg, written_value, mem_written,
  // divide_by_zero, zero pad
  output logic [47:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic        cfg_data
);
  logic [4:0] cfg;
  mse_cmd_t cmd;
  mse_sts_t sts;
  logic [DataW+8:0] result;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_REGWRITE: cfg[0] <= cfg_data;
        CFG_MEMREAD: cfg[1] <= cfg_data;
        CFG_MEMWRITE: cfg[2] <= cfg_data;
        CFG_BRANCH: cfg[3] <= cfg_data;
        CFG_JUMP: cfg[4] <= cfg_data;
        default: ;
      endcase
    end
  end

  mse_control u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .func(s_axis_tdata[3:0]), .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .cmd(cmd), .sts(sts)
  );

  mse_datapath #(.WordsPerBase(WORDS_PER_BASE)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .cfg(cfg),
    .func(s_axis_tdata[3:0]), .dest_reg(s_axis_tdata[8:4]),
    .src_a_reg(s_axis_tdata[13:9]), .src_b_reg(s_axis_tdata[18:14]),
    .immediate(s_axis_tdata[50:19]), .byte_offset(s_axis_tdata[59:51]),
    .result(result)
  );

  assign m_axis_tdata = {7'd0, result};
endmodule

// ----- sv/mse_ram.sv -----
// ---------------------------------------------------------------------------
// mse_ram
// generic single port ram with registered read
// ---------------------------------------------------------------------------
module mse_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ----- sv/mse_divider.sv -----
// ---------------------------------------------------------------------------
// mse_divider
// signed restoring divider, one quotient bit per cycle, truncates to zero
// ---------------------------------------------------------------------------
module mse_divider import mse_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DataW-1:0] dividend,
  input  logic [DataW-1:0] divisor,
  output logic             done,
  output logic [DataW-1:0] quotient
);
  logic [DataW-1:0] rem, quo, dvs;
  logic [5:0] count;
  logic busy, neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= 6'd0;
        rem <= '0;
        quo <= dividend[DataW-1] ? -dividend : dividend;
        dvs <= divisor[DataW-1] ? -divisor : divisor;
        neg <= dividend[DataW-1] ^ divisor[DataW-1];
      end else if (busy) begin
        if ({1'b0, rem[DataW-2:0], quo[DataW-1]} >= {1'b0, dvs} || rem[DataW-1]) begin
          rem <= {rem[DataW-2:0], quo[DataW-1]} - dvs;
          quo <= {quo[DataW-2:0], 1'b1};
        end else begin
          rem <= {rem[DataW-2:0], quo[DataW-1]};
          quo <= {quo[DataW-2:0], 1'b0};
        end
        count <= count + 6'd1;
        if (count == 6'(DataW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = neg ? -quo : quo;
endmodule

// ----- sv/mse_datapath.sv -----
// ---------------------------------------------------------------------------
// mse_datapath
// register file, data store, alu, divider and result register
// ---------------------------------------------------------------------------
module mse_datapath import mse_pkg::*; #(
  parameter int unsigned WordsPerBase = 128
) (
  input  logic                clk,
  input  logic                rst,
  input  mse_cmd_t            cmd,
  output mse_sts_t            sts,
  input  logic [4:0]          cfg,
  input  logic [3:0]          func,
  input  logic [RegIdxW-1:0]  dest_reg,
  input  logic [RegIdxW-1:0]  src_a_reg,
  input  logic [RegIdxW-1:0]  src_b_reg,
  input  logic [DataW-1:0]    immediate,
  input  logic [8:0]          byte_offset,
  output logic [DataW+8:0]    result
);
  localparam int unsigned Depth = NumRegs * WordsPerBase;
  localparam int unsigned AddrW = $clog2(Depth);

  logic [DataW-1:0] regs [NumRegs];
  logic [3:0] fn;
  logic [RegIdxW-1:0] rd, ra, rb;
  logic [DataW-1:0] imm, va, vb, vd;
  logic [8:0] off;
  logic [AddrW-1:0] clr_addr, addr, word;
  logic [6:0] word_full;
  logic [DataW-1:0] ram_q, div_q, value, product;
  logic ram_we, wr, memw, dz, redir;
  logic [AddrW:0] clr_cnt;

  assign word_full = off[8:2];

  // word index wrapped into its base region
  always_comb begin
    word = '0;
    for (int i = 0; i < 128; i++) begin
      if (word_full == 7'(i)) word = AddrW'(i % WordsPerBase);
    end
  end

  assign addr = cmd.clear_step ? clr_addr
              : AddrW'(ra) * AddrW'(WordsPerBase) + word;
  assign ram_we = cmd.clear_step || (cmd.exec && fn == FN_SW && cfg[CFG_MEMWRITE]);
  assign sts.clear_done = clr_cnt == (AddrW+1)'(Depth);

  mse_ram #(.Width(DataW), .Depth(Depth)) u_ram (
    .clk(clk), .we(ram_we), .addr(addr),
    .wdata(cmd.clear_step ? '0 : vd), .rdata(ram_q)
  );

  mse_divider u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .dividend(va), .divisor(vb),
    .done(sts.div_done), .quotient(div_q)
  );

  always_comb begin
    wr = 1'b0;
    memw = 1'b0;
    dz = 1'b0;
    redir = 1'b0;
    value = '0;
    case (fn)
      FN_ADDI: begin wr = 1'b1; value = va + imm; end
      FN_SUBI: begin wr = 1'b1; value = va - imm; end
      FN_BEQ: redir = cfg[CFG_BRANCH] && va == vb;
      FN_JUMP: redir = cfg[CFG_JUMP];
      FN_ADD: begin wr = cfg[CFG_REGWRITE]; value = va + vb; end
      FN_SUB: begin wr = cfg[CFG_REGWRITE]; value = va - vb; end
      FN_MUL: begin wr = cfg[CFG_REGWRITE]; value = product; end
      FN_DIV: begin
        dz = cfg[CFG_REGWRITE] && vb == '0;
        wr = cfg[CFG_REGWRITE] && vb != '0;
        value = div_q;
      end
      FN_LW: begin wr = cfg[CFG_REGWRITE] | cfg[CFG_MEMREAD]; value = ram_q; end
      FN_SW: memw = cfg[CFG_MEMWRITE];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      clr_addr <= '0;
      for (int i = 0; i < NumRegs; i++) regs[i] <= '0;
    end else begin
      if (cmd.clear_step) begin
        clr_addr <= clr_addr + AddrW'(1);
        clr_cnt <= clr_cnt + (AddrW+1)'(1);
      end
      if (cmd.exec && wr) regs[rd] <= value;
    end
    if (cmd.load) begin
      fn <= func;
      rd <= dest_reg;
      ra <= src_a_reg;
      rb <= src_b_reg;
      imm <= immediate;
      off <= byte_offset;
    end
    if (cmd.rd_regs) begin
      va <= regs[ra];
      vb <= regs[rb];
      vd <= regs[rd];
    end
    product <= va * vb;
    if (cmd.exec) begin
      result <= {dz, memw, wr ? value : '0, wr ? rd : '0, wr, redir};
    end
  end
endmodule

// ----- sv/mse_control.sv -----
// ---------------------------------------------------------------------------
// mse_control
// sequencer: clearing pass, operand read, divide wait, execute and result handoff
// ---------------------------------------------------------------------------
module mse_control import mse_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic [3:0] func,
  output logic     out_valid,
  input  logic     out_ready,
  output mse_cmd_t cmd,
  input  mse_sts_t sts
);
  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_WAIT, S_DIV, S_EXEC, S_OUT} state_t;
  state_t state;
  logic [3:0] fn;

  assign in_ready = state == S_IDLE;

  always_comb begin
    cmd = '0;
    cmd.clear_step = state == S_CLEAR && !sts.clear_done;
    cmd.load = in_valid && in_ready;
    cmd.rd_regs = state == S_READ;
    cmd.div_start = state == S_WAIT && fn == FN_DIV;
    cmd.exec = state == S_EXEC;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: if (sts.clear_done) state <= S_IDLE;
        S_IDLE: if (in_valid) begin
          fn <= func;
          state <= S_READ;
        end
        S_READ: state <= S_WAIT;
        S_WAIT: state <= (fn == FN_DIV) ? S_DIV : S_EXEC;
        S_DIV: if (sts.div_done) state <= S_EXEC;
        S_EXEC: begin
          out_valid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: if (out_ready) begin
          out_valid <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- sv/mse_checker.sv -----
// ---------------------------------------------------------------------------
// mse_checker
// port-level checks of the execute unit
// ---------------------------------------------------------------------------
`include "mips_subset_execute_with_control_lines_unit_macros.svh"
module mse_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata
);
  `MSE_ASSERT_IMP(a_one_at_a_time, m_axis_tvalid, !s_axis_tready, "input taken during result")
  `MSE_ASSERT_IMP(a_wr_idle, !m_axis_tdata[1] && m_axis_tvalid, m_axis_tdata[38:2] == '0, "stale write fields")
  `MSE_ASSERT_IMP(a_dz_no_wr, m_axis_tvalid && m_axis_tdata[40], !m_axis_tdata[1], "write with zero divisor")
  `MSE_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped")
  `MSE_ASSERT_NEXT(a_after_in, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready after accept")
endmodule

bind mips_subset_execute_with_control_lines_unit mse_checker u_chk (.*);

// ----- tb/tb_top.sv -----
// ---------------------------------------------------------------------------
// tb_top
// drives decoded instructions into the mips subset execute unit and checks
// every result against a behavioral model with its own register file, data
// store and control lines, under random sender gaps and receiver stalls
// ---------------------------------------------------------------------------
module tb_top;
  import mse_pkg::*;

  localparam int unsigned WordsPerBase = 128;

  typedef struct packed {
    logic [3:0]  func;
    logic [4:0]  rd;
    logic [4:0]  ra;
    logic [4:0]  rb;
    logic [31:0] imm;
    logic [8:0]  offset;
  } instr_t;

  typedef struct packed {
    logic        redirect;
    logic        reg_written;
    logic [4:0]  written_reg;
    logic [31:0] written_value;
    logic        mem_written;
    logic        divide_by_zero;
  } outcome_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // func, dest_reg, src_a_reg, src_b_reg, immediate, byte_offset, zero pad
  logic [63:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // redirect, reg_written, written_reg, written_value, mem_written,
  // divide_by_zero, zero pad
  logic [47:0] m_axis_tdata;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic        cfg_data;

  mips_subset_execute_with_control_lines_unit #(.WORDS_PER_BASE(WordsPerBase)) dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // model state
  logic [31:0] model_regs [32];
  logic [31:0] model_store [32*WordsPerBase];
  logic        line_regwrite, line_memread, line_memwrite, line_branch, line_jump;

  instr_t   pending_instrs [$];
  outcome_t expected_outcomes [$];
  int       mismatches = 0;
  int       results_seen = 0;
  int       gap_left = 0;
  int       burst_left = 0;
  int       stall_phase = 0;
  bit       hold_sender = 0;
  int       redirects_seen = 0, writes_seen = 0, stores_seen = 0, dz_seen = 0;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic logic [63:0] pack_instr(instr_t it);
    return {4'd0, it.offset, it.imm, it.rb, it.ra, it.rd, it.func};
  endfunction

  function automatic outcome_t unpack_outcome(logic [47:0] d);
    outcome_t o;
    o.redirect       = d[0];
    o.reg_written    = d[1];
    o.written_reg    = d[6:2];
    o.written_value  = d[38:7];
    o.mem_written    = d[39];
    o.divide_by_zero = d[40];
    return o;
  endfunction

  function automatic int store_addr(logic [4:0] base, logic [8:0] offset);
    return int'(base) * WordsPerBase + (int'(offset >> 2) % WordsPerBase);
  endfunction

  // executes one instruction on the model and returns its outcome
  function automatic outcome_t execute_instr(instr_t it);
    outcome_t o;
    logic [31:0] va, vb, val;
    logic wr;
    longint qa, qb;
    o = '0;
    va = model_regs[it.ra];
    vb = model_regs[it.rb];
    val = '0;
    wr = 0;
    case (it.func)
      FN_ADDI: begin val = va + it.imm; wr = 1; end
      FN_SUBI: begin val = va - it.imm; wr = 1; end
      FN_BEQ:  o.redirect = line_branch && (va == vb);
      FN_JUMP: o.redirect = line_jump;
      FN_ADD:  if (line_regwrite) begin val = va + vb; wr = 1; end
      FN_SUB:  if (line_regwrite) begin val = va - vb; wr = 1; end
      FN_MUL:  if (line_regwrite) begin val = va * vb; wr = 1; end
      FN_DIV: begin
        if (line_regwrite) begin
          if (vb == 0) o.divide_by_zero = 1;
          else begin
            qa = longint'(signed'(va));
            qb = longint'(signed'(vb));
            val = 32'(qa / qb);
            wr = 1;
          end
        end
      end
      FN_LW: if (line_regwrite || line_memread) begin
        val = model_store[store_addr(it.ra, it.offset)];
        wr = 1;
      end
      FN_SW: if (line_memwrite) begin
        model_store[store_addr(it.ra, it.offset)] = model_regs[it.rd];
        o.mem_written = 1;
      end
      default: ;
    endcase
    if (wr) begin
      model_regs[it.rd] = val;
      o.reg_written = 1;
      o.written_reg = it.rd;
      o.written_value = val;
    end
    return o;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 0;
      s_axis_tdata <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_outcomes.push_back(execute_instr(pending_instrs.pop_front()));
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (pending_instrs.size() != 0 && !hold_sender && gap_left == 0 &&
            !(s_axis_tvalid && s_axis_tready && pending_instrs.size() == 0)) begin
          s_axis_tvalid <= 1;
          s_axis_tdata <= pack_instr(pending_instrs[0]);
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
          end
          burst_left--;
          if (burst_left == 0) gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end else begin
          s_axis_tvalid <= 0;
          if (gap_left > 0) gap_left--;
        end
      end
    end
  end

  // monitor with a stall pattern of its own
  always @(posedge clk) begin
    outcome_t got, want;
    if (rst) begin
      m_axis_tready <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = unpack_outcome(m_axis_tdata);
        results_seen++;
        if (expected_outcomes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", m_axis_tdata);
        end else begin
          want = expected_outcomes.pop_front();
          if (got !== want || m_axis_tdata[47:41] !== '0) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch at result %0d: expected %p, actual %p",
                       results_seen, want, got);
          end
          redirects_seen += want.redirect;
          writes_seen += want.reg_written;
          stores_seen += want.mem_written;
          dz_seen += want.divide_by_zero;
        end
      end
      stall_phase = (stall_phase + 1) % 64;
      if (stall_phase < 20) m_axis_tready <= 1;
      else if (stall_phase < 40) m_axis_tready <= ($urandom_range(0, 3) != 0);
      else m_axis_tready <= ($urandom_range(0, 1) != 0);
    end
  end

  task automatic wait_idle();
    while (pending_instrs.size() != 0 || s_axis_tvalid || expected_outcomes.size() != 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_line(logic [2:0] idx, logic value);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      CFG_REGWRITE: line_regwrite = value;
      CFG_MEMREAD:  line_memread = value;
      CFG_MEMWRITE: line_memwrite = value;
      CFG_BRANCH:   line_branch = value;
      default:      line_jump = value;
    endcase
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic set_lines(logic [4:0] bits);
    write_line(CFG_REGWRITE, bits[0]);
    write_line(CFG_MEMREAD, bits[1]);
    write_line(CFG_MEMWRITE, bits[2]);
    write_line(CFG_BRANCH, bits[3]);
    write_line(CFG_JUMP, bits[4]);
  endtask

  task automatic push(logic [3:0] f, logic [4:0] rd, logic [4:0] ra, logic [4:0] rb,
                      logic [31:0] imm, logic [8:0] off);
    instr_t it;
    it.func = f; it.rd = rd; it.ra = ra; it.rb = rb; it.imm = imm; it.offset = off;
    pending_instrs.push_back(it);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h7FFF_FFFF;
      3: return 32'($urandom_range(0, 3));
      4: return 32'($urandom_range(0, 200)) - 32'd100;
      default: return $urandom();
    endcase
  endfunction

  // random items: addi set-ups mixed with instructions on registers 0 to 7
  task automatic push_random(int count);
    logic [3:0] f;
    repeat (count) begin
      if ($urandom_range(0, 9) < 3)
        push(FN_ADDI, 5'($urandom()), 5'($urandom()), 5'($urandom()), rand_word(),
             9'($urandom()));
      else begin
        f = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(10, 15))
                                          : 4'($urandom_range(0, 9));
        push(f, 5'($urandom_range(0, 7)), 5'($urandom_range(0, 7)),
             5'($urandom_range(0, 7)), rand_word(),
             ($urandom_range(0, 3) == 0) ? 9'($urandom()) : 9'($urandom_range(0, 15)));
      end
    end
  endtask

  initial begin
    for (int i = 0; i < 32; i++) model_regs[i] = '0;
    for (int i = 0; i < 32*WordsPerBase; i++) model_store[i] = '0;
    {line_regwrite, line_memread, line_memwrite, line_branch, line_jump} = '0;
    rst = 1;
    cfg_we = 0;
    cfg_index = CFG_REGWRITE;
    cfg_data = 0;
    repeat (12) @(posedge clk);
    rst <= 0;

    // all lines low: gated instructions do nothing
    push(FN_ADDI, 5'd0, 5'd0, 5'd0, 32'h7FFF_FFFF, 9'd0);
    push(FN_ADD, 5'd1, 5'd0, 5'd0, 32'd0, 9'd0);
    push(FN_DIV, 5'd1, 5'd0, 5'd2, 32'd0, 9'd0);
    push(FN_SW, 5'd0, 5'd3, 5'd0, 32'd0, 9'd4);
    push(FN_LW, 5'd4, 5'd3, 5'd0, 32'd0, 9'd4);
    push(FN_BEQ, 5'd0, 5'd2, 5'd3, 32'd0, 9'd0);
    push(FN_JUMP, 5'd0, 5'd0, 5'd0, 32'd0, 9'd0);
    push(4'hF, 5'd31, 5'd31, 5'd31, 32'hFFFF_FFFF, 9'h1FF);
    wait_idle();

    set_lines(5'b11111);
    push(FN_ADDI, 5'd1, 5'd2, 5'd0, 32'h8000_0000, 9'd0);
    push(FN_SUBI, 5'd2, 5'd2, 5'd0, 32'd1, 9'd0);
    push(FN_DIV, 5'd3, 5'd1, 5'd2, 32'd0, 9'd0);
    push(FN_DIV, 5'd4, 5'd1, 5'd5, 32'd0, 9'd0);
    push(FN_ADDI, 5'd5, 5'd5, 5'd0, 32'hFFFF_FFF9, 9'd0);
    push(FN_ADDI, 5'd6, 5'd6, 5'd0, 32'd2, 9'd0);
    push(FN_DIV, 5'd7, 5'd5, 5'd6, 32'd0, 9'd0);
    push(FN_MUL, 5'd8, 5'd1, 5'd2, 32'd0, 9'd0);
    push(FN_SUB, 5'd9, 5'd1, 5'd6, 32'd0, 9'd0);
    push(FN_ADD, 5'd31, 5'd1, 5'd1, 32'd0, 9'd0);
    push(FN_SW, 5'd5, 5'd31, 5'd0, 32'd0, 9'h1FF);
    push(FN_LW, 5'd10, 5'd31, 5'd0, 32'd0, 9'd124);
    push(FN_BEQ, 5'd0, 5'd3, 5'd1, 32'd0, 9'd0);
    push(FN_JUMP, 5'd0, 5'd0, 5'd0, 32'd0, 9'd0);
    push_random(120);
    wait_idle();

    set_lines(5'b00010);
    push_random(100);
    wait_idle();
    hold_sender = 0;
    set_lines(5'b10101);
    push_random(100);
    wait_idle();
    set_lines(5'b01010);
    push_random(100);
    wait_idle();
    set_lines(5'b11111);
    push_random(200);
    wait_idle();

    $display("covered %0d results: %0d register writes, %0d stores,", results_seen,
             writes_seen, stores_seen);
    $display("  %0d redirects, %0d zero divides", redirects_seen, dz_seen);
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #(20 * 500000);
    $display("CHECK FAILED");
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+sv
sv/mse_pkg.sv
sv/mse_ram.sv
sv/mse_divider.sv
sv/mse_datapath.sv
sv/mse_control.sv
sv/mips_subset_execute_with_control_lines_unit.sv
sv/mse_checker.sv
tb/tb_top.sv
